// File: hdl/pmpf_pkg.sv
package pmpf_pkg;

  // Default number of data bytes between the packet id and the end bytes.
  localparam int DATA_LENGTH_DEF = 59;

  // Framing bytes.
  localparam logic [7:0] START_BYTE0 = 8'd254;
  localparam logic [7:0] START_BYTE1 = 8'd255;
  localparam logic [7:0] END_BYTE0   = 8'd255;
  localparam logic [7:0] END_BYTE1   = 8'd254;

  // Packet position of the unit id byte.
  localparam int UNIT_ID_POS = 32;

  // Reset values of the configuration registers.
  localparam logic [7:0] PACKET_ID_RST = 8'd3;
  localparam logic [7:0] UNIT_ID_RST   = 8'd3;

  // Configuration register indexes.
  localparam logic REG_PACKET_ID = 1'b0;
  localparam logic REG_UNIT_ID   = 1'b1;

  // Event codes on the result channel.
  localparam logic [2:0] EV_PROGRESS = 3'd0;
  localparam logic [2:0] EV_RESYNC   = 3'd1;
  localparam logic [2:0] EV_VALID    = 3'd2;
  localparam logic [2:0] EV_BAD_UNIT = 3'd3;
  localparam logic [2:0] EV_BAD_SUM  = 3'd4;

  // Byte classes handed from the front to the back.
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_RESYNC = 2'd1;
  localparam logic [1:0] KIND_CHECK  = 2'd2;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic       unit_sample;  // this byte sits at the unit id position
    logic       unit_ok;      // and it equals the expected unit id
  } ctl_t;

  typedef struct packed {
    logic [7:0] data;
    logic [6:0] pos;
    ctl_t       ctl;
  } qent_t;

endpackage

// File: hdl/pmpf_in_if.sv
interface pmpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// File: hdl/pmpf_out_if.sv
interface pmpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] echo_byte;
  logic [6:0] byte_position;
  logic [2:0] event_res;

  modport source (output valid, output echo_byte, output byte_position, output event_res,
                  input ready);
  modport sink (input valid, input echo_byte, input byte_position, input event_res,
                output ready);
endinterface

// File: hdl/pmpf_front.sv
module pmpf_front #(
  parameter int DATA_LENGTH = pmpf_pkg::DATA_LENGTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        data,
  input  logic [7:0]        packet_id,
  input  logic [7:0]        unit_id,
  output pmpf_pkg::qent_t   ent
);

  localparam int PW = $clog2(DATA_LENGTH + 6);
  localparam logic [PW-1:0] POS_ID    = PW'(2);
  localparam logic [PW-1:0] POS_END0  = PW'(DATA_LENGTH + 3);
  localparam logic [PW-1:0] POS_END1  = PW'(DATA_LENGTH + 4);
  localparam logic [PW-1:0] POS_CHECK = PW'(DATA_LENGTH + 5);
  localparam logic [PW-1:0] POS_UNIT  = PW'(pmpf_pkg::UNIT_ID_POS);

  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  logic          mismatch;
  logic          is_check;

  // Compare against the byte expected at the fixed framing positions.
  always_comb begin
    mismatch = 1'b0;
    if (pos == '0) begin
      mismatch = (data != pmpf_pkg::START_BYTE0);
    end else if (pos == PW'(1)) begin
      mismatch = (data != pmpf_pkg::START_BYTE1);
    end else if (pos == POS_ID) begin
      mismatch = (data != packet_id);
    end else if (pos == POS_END0) begin
      mismatch = (data != pmpf_pkg::END_BYTE0);
    end else if (pos == POS_END1) begin
      mismatch = (data != pmpf_pkg::END_BYTE1);
    end
  end

  assign is_check = (pos >= POS_CHECK);

  always_comb begin
    ent.data            = data;
    ent.pos             = 7'(pos);
    ent.ctl.unit_sample = (pos == POS_UNIT);
    ent.ctl.unit_ok     = (data == unit_id);
    if (mismatch) begin
      ent.ctl.kind = pmpf_pkg::KIND_RESYNC;
    end else if (is_check) begin
      ent.ctl.kind = pmpf_pkg::KIND_CHECK;
    end else begin
      ent.ctl.kind = pmpf_pkg::KIND_DATA;
    end
  end

  // Restart the search after a drop or a complete packet, else advance.
  assign pos_next = (mismatch || is_check) ? '0 : pos + PW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (take) begin
      pos <= pos_next;
    end
  end

endmodule

// File: hdl/pmpf_queue.sv
module pmpf_queue #(
  parameter int DEPTH = pmpf_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pmpf_pkg::qent_t push_ent,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output pmpf_pkg::qent_t pop_ent
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pmpf_pkg::qent_t slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full    = (count == CW'(DEPTH));
  assign avail   = (count != '0);
  assign pop_ent = slots[rd_ptr];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: hdl/pmpf_back.sv
module pmpf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            avail,
  input  pmpf_pkg::qent_t ent,
  output logic            pop,
  pmpf_out_if.source      res_out
);

  logic [7:0] sum;
  logic       matched;
  logic [2:0] ev;
  logic       valid;

  // Take the next queued byte when the output register is empty or draining.
  assign pop = avail && (!valid || res_out.ready);

  always_comb begin
    case (ent.ctl.kind)
      pmpf_pkg::KIND_DATA: begin
        ev = pmpf_pkg::EV_PROGRESS;
      end
      pmpf_pkg::KIND_RESYNC: begin
        ev = pmpf_pkg::EV_RESYNC;
      end
      pmpf_pkg::KIND_CHECK: begin
        if (!matched) begin
          ev = pmpf_pkg::EV_BAD_UNIT;
        end else if (ent.data != sum) begin
          ev = pmpf_pkg::EV_BAD_SUM;
        end else begin
          ev = pmpf_pkg::EV_VALID;
        end
      end
      default: begin
        ev = pmpf_pkg::EV_RESYNC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      sum     <= '0;
      matched <= 1'b0;
    end else begin
      if (pop) begin
        valid <= 1'b1;
      end else if (res_out.ready) begin
        valid <= 1'b0;
      end
      if (pop) begin
        if (ent.ctl.kind == pmpf_pkg::KIND_DATA) begin
          sum <= sum + ent.data;
          if (ent.ctl.unit_sample) begin
            matched <= ent.ctl.unit_ok;
          end
        end else begin
          sum     <= '0;
          matched <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_out.echo_byte     <= ent.data;
      res_out.byte_position <= ent.pos;
      res_out.event_res     <= ev;
    end
  end

  assign res_out.valid = valid;

endmodule

// File: hdl/power_monitor_packet_framer.sv
// Packet framer for a serial byte stream. It hunts for fixed packets of
// DATA_LENGTH + 6 bytes (start bytes 254 and 255, packet id, DATA_LENGTH data
// bytes, end bytes 255 and 254, then a checksum byte equal to the mod-256 sum
// of all earlier packet bytes) and echoes every byte it takes on the result
// channel together with its position in the candidate packet (low 7 bits)
// and an event code: in progress, resync drop, valid packet, bad unit id or
// bad checksum. A wrong start, id or end byte drops the candidate and the
// next byte is tried as a new start. On the checksum byte the unit id (packet
// position 32) is judged first, then the checksum. The block takes one byte
// per clock cycle while the result channel is not stalled; a byte's result
// passes through a queue slot, then the output register, and is held there
// until the result channel takes it. That rate is set by the position
// counter in the front end and the running-sum adder in the back end, each
// of which handles one byte per cycle. Configuration writes (index 0:
// expected packet id, index 1: expected unit id, both reset to 3) are meant
// to happen only while no byte is in flight.
module power_monitor_packet_framer #(
  parameter int DATA_LENGTH = pmpf_pkg::DATA_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic       wr_index,
  input  logic [7:0] wr_data,
  pmpf_in_if.sink    byte_in,
  pmpf_out_if.source res_out
);

  logic [7:0]      packet_id;
  logic [7:0]      unit_id;
  logic            q_full;
  logic            q_avail;
  logic            q_pop;
  logic            take;
  pmpf_pkg::qent_t front_ent;
  pmpf_pkg::qent_t back_ent;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_id <= pmpf_pkg::PACKET_ID_RST;
      unit_id   <= pmpf_pkg::UNIT_ID_RST;
    end else if (wr_en) begin
      case (wr_index)
        pmpf_pkg::REG_PACKET_ID: begin
          packet_id <= wr_data;
        end
        pmpf_pkg::REG_UNIT_ID: begin
          unit_id <= wr_data;
        end
        default: begin
          packet_id <= packet_id;
        end
      endcase
    end
  end

  // Accept a byte whenever the queue has room; the front classifies it in
  // the same cycle and the queue holds the tagged byte for the back end.
  assign byte_in.ready = !q_full;
  assign take          = byte_in.valid && byte_in.ready;

  pmpf_front #(
    .DATA_LENGTH (DATA_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data      (byte_in.data_byte),
    .packet_id (packet_id),
    .unit_id   (unit_id),
    .ent       (front_ent)
  );

  // Short queue: lets the front keep taking bytes while a result is stalled.
  pmpf_queue #(
    .DEPTH (pmpf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (take),
    .push_ent (front_ent),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_ent  (back_ent)
  );

  // Back end: running sum, unit id flag, event code and output register.
  pmpf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .avail   (q_avail),
    .ent     (back_ent),
    .pop     (q_pop),
    .res_out (res_out)
  );

endmodule

// File: hdl/pmpf_checker.sv
module pmpf_checker #(
  parameter int DATA_LENGTH = pmpf_pkg::DATA_LENGTH_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] echo_byte,
  input logic [6:0] byte_position,
  input logic [2:0] event_res
);

  localparam logic [6:0] POS_END0  = 7'(DATA_LENGTH + 3);
  localparam logic [6:0] POS_END1  = 7'(DATA_LENGTH + 4);
  localparam logic [6:0] POS_CHECK = 7'(DATA_LENGTH + 5);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(echo_byte)
      && $stable(byte_position) && $stable(event_res))
    else $error("result changed while stalled");

  // Drops happen only at framing positions.
  a_resync_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == pmpf_pkg::EV_RESYNC |->
      byte_position == 7'd0 || byte_position == 7'd1 || byte_position == 7'd2
      || byte_position == POS_END0 || byte_position == POS_END1)
    else $error("resync at a data position");

  // Verdicts come only on the checksum byte.
  a_verdict_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == pmpf_pkg::EV_VALID || event_res == pmpf_pkg::EV_BAD_UNIT
      || event_res == pmpf_pkg::EV_BAD_SUM) |-> byte_position == POS_CHECK)
    else $error("packet verdict off the checksum position");

  // A byte kept at the first position must be the first start byte.
  a_start_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == pmpf_pkg::EV_PROGRESS && byte_position == 7'd0 |->
      echo_byte == pmpf_pkg::START_BYTE0)
    else $error("packet started on a wrong byte");

endmodule

bind power_monitor_packet_framer pmpf_checker #(
  .DATA_LENGTH (DATA_LENGTH)
) u_pmpf_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (res_out.valid),
  .out_ready     (res_out.ready),
  .echo_byte     (res_out.echo_byte),
  .byte_position (res_out.byte_position),
  .event_res     (res_out.event_res)
);
